// ===== rtl/bblc_pkg.sv =====
package bblc_pkg;

    // Width of one packed black level or white limit.
    localparam int LANE_W = 16;

    // Width of the configuration register index and data.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLACK_LEVELS   = 3'd0,
        CFG_WHITE_LIMITS   = 3'd1,
        CFG_COLOR_ORDER    = 3'd2,
        CFG_CORRECT_ENABLE = 3'd3,
        CFG_LINE_WIDTH     = 3'd4
    } cfg_index_t;

    // Bayer layouts, named by the two pixels of the first even row.
    typedef enum logic [1:0] {
        ORDER_RGGB = 2'd0,
        ORDER_GRBG = 2'd1,
        ORDER_GBRG = 2'd2,
        ORDER_BGGR = 2'd3
    } color_order_t;

    // Channel lanes inside the packed level registers.
    typedef enum logic [1:0] {
        CH_R  = 2'd0,
        CH_GR = 2'd1,
        CH_GB = 2'd2,
        CH_B  = 2'd3
    } chan_t;

    // Parity of a pixel's place in the color filter array.
    typedef struct packed {
        logic row_odd;
        logic col_odd;
    } pos_t;

    localparam logic [CFG_DATA_W-1:0] BLACK_LEVELS_RESET = '0;
    localparam logic [CFG_DATA_W-1:0] WHITE_LIMITS_RESET = '1;
    localparam logic [13:0]           LINE_WIDTH_RESET   = 14'd1920;

    // In RGGB the channel code is simply {row parity, column parity}. The
    // other three layouts are that pattern shifted by one row and/or one
    // column, which flips the matching bit of the code, so the order code
    // works as an XOR mask.
    function automatic chan_t chan_select(input color_order_t order, input pos_t pos);
        logic [1:0] code;
        code = {pos.row_odd, pos.col_odd} ^ order;
        return chan_t'(code);
    endfunction

endpackage

// ===== rtl/bblc_pos.sv =====
module bblc_pos #(
    parameter int MAX_LINE_WIDTH = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [13:0]       line_width,
    output bblc_pkg::pos_t    pos
);

    localparam int CNT_W = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int CMP_W = (CNT_W + 1 > 15) ? CNT_W + 1 : 15;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_LINE_WIDTH);

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic             row_odd_reg;
    logic             row_odd_next;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] col_plus;
    logic             wrap;

    // A width of zero behaves like one, since the compare always wraps.
    always_comb
    begin
        width_ext    = CMP_W'(line_width);
        width_eff    = (width_ext > MAX_W) ? MAX_W : width_ext;
        col_plus     = CMP_W'(col_reg) + CMP_W'(1);
        wrap         = (col_plus >= width_eff);
        col_next     = col_reg;
        row_odd_next = row_odd_reg;
        if (advance)
        begin
            if (wrap)
            begin
                col_next     = '0;
                row_odd_next = ~row_odd_reg;
            end
            else
            begin
                col_next = col_plus[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_odd_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_odd_reg <= row_odd_next;
        end
    end

    assign pos.row_odd = row_odd_reg;
    assign pos.col_odd = col_reg[0];

endmodule

// ===== rtl/bblc_correct.sv =====
module bblc_correct #(
    parameter int PIXEL_BITS = 16
) (
    input  logic [PIXEL_BITS-1:0]          pixel,
    input  logic                           enable,
    input  logic [bblc_pkg::LANE_W-1:0]    black_level,
    input  logic [bblc_pkg::LANE_W-1:0]    white_limit,
    output logic [PIXEL_BITS-1:0]          result
);

    logic [bblc_pkg::LANE_W-1:0] pix_ext;
    logic [bblc_pkg::LANE_W-1:0] diff;
    logic [bblc_pkg::LANE_W-1:0] clipped;

    // The difference never exceeds the pixel, and the clip only lowers it,
    // so the result always fits back into PIXEL_BITS.
    always_comb
    begin
        pix_ext = bblc_pkg::LANE_W'(pixel);
        diff    = (pix_ext > black_level) ? (pix_ext - black_level) : '0;
        clipped = (diff > white_limit) ? white_limit : diff;
        result  = enable ? clipped[PIXEL_BITS-1:0] : pixel;
    end

endmodule

// ===== rtl/bayer_black_level_correct_top.sv =====
// Black level correction for a raw Bayer pixel stream.
//
// Pixels arrive in raster order on the s_axis channel, one per item, and the
// corrected pixels leave on the m_axis channel in the same order, one result
// for every input item. The block counts columns against line_width and flips
// the row parity at each line end; with color_order this selects the R, Gr,
// Gb or B lane of black_levels and white_limits for each pixel. When
// correct_enable is set the black level is subtracted and the result clamped
// between zero and the lane's white limit; otherwise the pixel passes through.
//
// An accepted pixel passes an input register, which holds the pixel and its
// channel, and a result register, which holds the corrected value. One item
// is accepted every clock unless the receiver stalls; then both stages hold
// and s_axis_tready drops in the same cycle, so nothing is lost. Reset empties
// both stages, puts the next pixel at row 0, column 0, and returns the
// configuration registers to their defaults. Configuration, written through
// cfg_wr_en/cfg_index/cfg_data, takes effect on the next pixel; the user must
// write it only while the stream is idle, as the block does not enforce this.
module bayer_black_level_correct_top #(
    parameter int MAX_LINE_WIDTH = 8192,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [15:0]                          s_axis_tdata,   // [15:0] raw_pixel

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,   // [15:0] corrected_pixel

    input  logic                                 cfg_wr_en,
    input  logic [bblc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bblc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [63:0]                  black_levels_reg;
    logic [63:0]                  white_limits_reg;
    bblc_pkg::color_order_t       color_order_reg;
    logic                         correct_enable_reg;
    logic [13:0]                  line_width_reg;

    // Pipeline registers.
    logic                         in_valid_reg;
    logic [PIXEL_BITS-1:0]        in_pixel_reg;
    bblc_pkg::chan_t              in_chan_reg;
    logic                         out_valid_reg;
    logic [PIXEL_BITS-1:0]        out_pixel_reg;
    logic [PIXEL_BITS-1:0]        out_pixel_next;

    logic                         advance;
    logic                         accept;
    bblc_pkg::pos_t               pos;
    logic [bblc_pkg::LANE_W-1:0]  black_level;
    logic [bblc_pkg::LANE_W-1:0]  white_limit;

    // The whole pipeline moves whenever the output register is free or is
    // being emptied this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_levels_reg   <= bblc_pkg::BLACK_LEVELS_RESET;
            white_limits_reg   <= bblc_pkg::WHITE_LIMITS_RESET;
            color_order_reg    <= bblc_pkg::ORDER_RGGB;
            correct_enable_reg <= 1'b0;
            line_width_reg     <= bblc_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bblc_pkg::CFG_BLACK_LEVELS:   black_levels_reg   <= cfg_data;
                bblc_pkg::CFG_WHITE_LIMITS:   white_limits_reg   <= cfg_data;
                bblc_pkg::CFG_COLOR_ORDER:
                    color_order_reg <= bblc_pkg::color_order_t'(cfg_data[1:0]);
                bblc_pkg::CFG_CORRECT_ENABLE: correct_enable_reg <= cfg_data[0];
                bblc_pkg::CFG_LINE_WIDTH:     line_width_reg     <= cfg_data[13:0];
                default:                      ;
            endcase
        end
    end

    // Position of the next pixel; it steps once per accepted item.
    bblc_pos #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .line_width (line_width_reg),
        .pos        (pos)
    );

    // Input stage: pixel plus the channel it belongs to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_pixel_reg <= s_axis_tdata[PIXEL_BITS-1:0];
            in_chan_reg  <= bblc_pkg::chan_select(color_order_reg, pos);
        end
    end

    assign black_level = black_levels_reg[in_chan_reg * bblc_pkg::LANE_W +: bblc_pkg::LANE_W];
    assign white_limit = white_limits_reg[in_chan_reg * bblc_pkg::LANE_W +: bblc_pkg::LANE_W];

    bblc_correct #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_correct (
        .pixel       (in_pixel_reg),
        .enable      (correct_enable_reg),
        .black_level (black_level),
        .white_limit (white_limit),
        .result      (out_pixel_next)
    );

    // Result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_pixel_reg);

endmodule

// ===== test/bayer_black_level_correct_top_test.sv =====
`timescale 1ns / 100ps

// Keeps its own copy of the block's registers and raster position, works out
// the corrected pixel for every accepted raw pixel and holds it until the
// matching result leaves the block.
class corrected_pixel_tracker;
    localparam int MAX_WIDTH = 8192;

    logic [bblc_pkg::CFG_DATA_W-1:0] black_levels;
    logic [bblc_pkg::CFG_DATA_W-1:0] white_limits;
    bblc_pkg::color_order_t          order;
    logic                            enable;
    logic [13:0]                     line_width;
    int unsigned                     column;
    logic                            row_odd;

    logic [15:0] pending_pixels[$];
    int          checked;
    int          errors;

    function new();
        black_levels = bblc_pkg::BLACK_LEVELS_RESET;
        white_limits = bblc_pkg::WHITE_LIMITS_RESET;
        order        = bblc_pkg::ORDER_RGGB;
        enable       = 1'b0;
        line_width   = bblc_pkg::LINE_WIDTH_RESET;
        column       = 0;
        row_odd      = 1'b0;
        checked      = 0;
        errors       = 0;
    endfunction

    function void set_reg(bblc_pkg::cfg_index_t idx,
                          logic [bblc_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            bblc_pkg::CFG_BLACK_LEVELS:   black_levels = value;
            bblc_pkg::CFG_WHITE_LIMITS:   white_limits = value;
            bblc_pkg::CFG_COLOR_ORDER:    order = bblc_pkg::color_order_t'(value[1:0]);
            bblc_pkg::CFG_CORRECT_ENABLE: enable = value[0];
            bblc_pkg::CFG_LINE_WIDTH:     line_width = value[13:0];
            default:                      ;
        endcase
    endfunction

    // Channel of the pixel at the current row and column parity.
    function bblc_pkg::chan_t channel_at();
        logic col;
        col = column[0];
        case (order)
            bblc_pkg::ORDER_RGGB:
                return row_odd ? (col ? bblc_pkg::CH_B  : bblc_pkg::CH_GB)
                               : (col ? bblc_pkg::CH_GR : bblc_pkg::CH_R);
            bblc_pkg::ORDER_GRBG:
                return row_odd ? (col ? bblc_pkg::CH_GB : bblc_pkg::CH_B)
                               : (col ? bblc_pkg::CH_R  : bblc_pkg::CH_GR);
            bblc_pkg::ORDER_GBRG:
                return row_odd ? (col ? bblc_pkg::CH_GR : bblc_pkg::CH_R)
                               : (col ? bblc_pkg::CH_B  : bblc_pkg::CH_GB);
            default:
                return row_odd ? (col ? bblc_pkg::CH_R  : bblc_pkg::CH_GR)
                               : (col ? bblc_pkg::CH_GB : bblc_pkg::CH_B);
        endcase
    endfunction

    function logic [15:0] predict_corrected(logic [15:0] raw);
        bblc_pkg::chan_t ch;
        logic [15:0]     blk;
        logic [15:0]     wht;
        logic [15:0]     res;
        int unsigned     width;
        res = raw;
        if (enable) begin
            ch  = channel_at();
            blk = black_levels[int'(ch)*bblc_pkg::LANE_W +: bblc_pkg::LANE_W];
            wht = white_limits[int'(ch)*bblc_pkg::LANE_W +: bblc_pkg::LANE_W];
            res = (raw > blk) ? raw - blk : 16'd0;
            if (res > wht)
                res = wht;
        end
        // A width of zero wraps on every pixel, like a width of one.
        width = (line_width > MAX_WIDTH) ? MAX_WIDTH : line_width;
        if (column + 1 >= width) begin
            column  = 0;
            row_odd = ~row_odd;
        end else begin
            column = column + 1;
        end
        return res;
    endfunction

    function void note_raw(logic [15:0] raw);
        pending_pixels.push_back(predict_corrected(raw));
    endfunction

    task report(string what);
        if (errors < 200)
            $display("mismatch: %s", what);
        errors++;
    endtask

    task check_corrected(logic [15:0] got);
        logic [15:0] want;
        if (pending_pixels.size() == 0) begin
            report($sformatf("corrected_pixel %h arrived with no item outstanding", got));
            return;
        end
        want = pending_pixels.pop_front();
        checked++;
        if (got !== want)
            report($sformatf("corrected_pixel got %h, want %h (result %0d)",
                             got, want, checked));
    endtask
endclass

module bayer_black_level_correct_top_test;

    // The run is stopped as failed if it ever gets this far.
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_ITEMS   = 830;
    localparam int LONG_HOLD      = 60;
    localparam int TRAILING_WAIT  = 20;

    typedef struct {
        logic [bblc_pkg::CFG_DATA_W-1:0] black_levels;
        logic [bblc_pkg::CFG_DATA_W-1:0] white_limits;
        bblc_pkg::color_order_t          order;
        logic                            enable;
        logic [13:0]                     line_width;
    } blc_setting_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [15:0]                      s_axis_tdata;    // [15:0] raw_pixel
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [15:0]                      m_axis_tdata;    // [15:0] corrected_pixel
    logic                             cfg_wr_en;
    logic [bblc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bblc_pkg::CFG_DATA_W-1:0]  cfg_data;

    corrected_pixel_tracker pixel_check = new();

    // Items accepted on the input side, and how many more the current burst
    // of the sender still holds before it takes a gap.
    int sent_count = 0;
    int burst_left = 0;
    int cycle_count = 0;
    bit long_hold_done = 1'b0;

    logic [15:0] pixel_list[$];

    bayer_black_level_correct_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog. A hung handshake or a missing result ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Both sides are sampled at the rising edge, before anything driven at
    // that edge takes effect. An accepted raw pixel is noted first, so that
    // its prediction is queued before any result of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pixel_check.note_raw(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                pixel_check.check_corrected(m_axis_tdata);
        end
    end

    // Receiver. Each time its mode counter runs out it picks a stall pattern:
    // always ready, a coin flip per cycle, or ready at phase 0 of three. Once,
    // while items are in flight and the sender keeps offering, it holds off for
    // a long stretch so that both pipeline stages fill and the input side stalls.
    initial
    begin
        int mode;
        int mode_left;
        int phase3;
        m_axis_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        phase3 = 0;
        forever begin
            @(posedge clk);
            if (!long_hold_done && pixel_check.checked >= 300
                && sent_count > pixel_check.checked && s_axis_tvalid) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = 64;
            end
            mode_left--;
            phase3 = (phase3 == 2) ? 0 : phase3 + 1;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= (phase3 == 0);
            endcase
        end
    end

    function automatic blc_setting_t make_setting(
        logic [bblc_pkg::CFG_DATA_W-1:0] black,
        logic [bblc_pkg::CFG_DATA_W-1:0] white,
        bblc_pkg::color_order_t          order,
        logic                            enable,
        logic [13:0]                     width);
        blc_setting_t s;
        s.black_levels = black;
        s.white_limits = white;
        s.order        = order;
        s.enable       = enable;
        s.line_width   = width;
        return s;
    endfunction

    // Random setting. Lanes lean toward the extremes and toward small black
    // levels; line widths lean toward short lines so that row parity flips
    // often, with zero, one, the maximum and oversized widths mixed in.
    function automatic blc_setting_t random_setting();
        blc_setting_t s;
        for (int lane = 0; lane < 4; lane++) begin
            case ($urandom_range(0, 3))
                0:       s.black_levels[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] = 16'h0000;
                1:       s.black_levels[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] = 16'hFFFF;
                2:       s.black_levels[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] =
                             16'($urandom_range(0, 4095));
                default: s.black_levels[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] =
                             16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       s.white_limits[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] = 16'hFFFF;
                1:       s.white_limits[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] = 16'h0000;
                2:       s.white_limits[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] =
                             16'($urandom_range(4096, 65535));
                default: s.white_limits[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W] =
                             16'($urandom_range(0, 65535));
            endcase
        end
        s.order  = bblc_pkg::color_order_t'($urandom_range(0, 3));
        s.enable = ($urandom_range(0, 5) != 0);
        case ($urandom_range(0, 9))
            0:       s.line_width = 14'd0;
            1:       s.line_width = 14'd1;
            2:       s.line_width = 14'd8192;
            3:       s.line_width = 14'($urandom_range(8193, 16383));
            4:       s.line_width = 14'd1920;
            default: s.line_width = 14'($urandom_range(2, 16));
        endcase
        return s;
    endfunction

    // Raw pixel for the random part: extremes, full-range values, and values
    // just around one of the current black levels where the clamp to zero
    // switches.
    function automatic logic [15:0] random_pixel();
        int lane;
        logic [15:0] blk;
        lane = $urandom_range(0, 3);
        blk = pixel_check.black_levels[lane*bblc_pkg::LANE_W +: bblc_pkg::LANE_W];
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return blk + 16'($urandom_range(0, 6)) - 16'd3;
        endcase
    endfunction

    // One register write. The enable stays high so that back-to-back writes
    // need no second assignment in the same step; apply_setting lowers it.
    task automatic write_reg(input bblc_pkg::cfg_index_t idx,
                             input logic [bblc_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        pixel_check.set_reg(idx, value);
    endtask

    task automatic apply_setting(input blc_setting_t s);
        write_reg(bblc_pkg::CFG_BLACK_LEVELS, s.black_levels);
        write_reg(bblc_pkg::CFG_WHITE_LIMITS, s.white_limits);
        write_reg(bblc_pkg::CFG_COLOR_ORDER, {{(bblc_pkg::CFG_DATA_W-2){1'b0}}, s.order});
        write_reg(bblc_pkg::CFG_CORRECT_ENABLE,
                  {{(bblc_pkg::CFG_DATA_W-1){1'b0}}, s.enable});
        write_reg(bblc_pkg::CFG_LINE_WIDTH,
                  {{(bblc_pkg::CFG_DATA_W-14){1'b0}}, s.line_width});
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one raw pixel and waits until it is accepted. Bursts of random
    // length are separated by random gaps; about half of the gaps are empty,
    // which leaves long stretches of back-to-back items.
    task automatic send_pixel(input logic [15:0] raw);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    // Sends the queued pixels, then stops and waits until every result has
    // come back, which leaves the block idle for the next register writes.
    task automatic stream_pixels();
        foreach (pixel_list[i])
            send_pixel(pixel_list[i]);
        s_axis_tvalid <= 1'b0;
        while (pixel_check.checked != sent_count)
            @(posedge clk);
    endtask

    initial
    begin
        int random_sent;
        int count;
        logic [bblc_pkg::CFG_DATA_W-1:0] lane_black;
        logic [bblc_pkg::CFG_DATA_W-1:0] lane_white;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = bblc_pkg::CFG_BLACK_LEVELS;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset correction is off, so pixels pass unchanged.
        pixel_list = {16'h0000, 16'hFFFF, 16'hA5A5, 16'h5A5A};
        stream_pixels();

        // Distinct black levels and white limits per lane and two-pixel lines,
        // so every channel of every layout is hit within four pixels. The
        // pixels cover a clamp to zero, a clamp to the white limit, a pixel
        // equal to its black level and ordinary subtraction.
        lane_black = 64'h0400_0300_0200_0100;
        lane_white = 64'h3000_2000_1000_0F00;
        apply_setting(make_setting(lane_black, lane_white, bblc_pkg::ORDER_RGGB, 1'b1, 14'd2));
        pixel_list = {16'h0000, 16'hFFFF, 16'h0350, 16'h0400};
        stream_pixels();
        apply_setting(make_setting(lane_black, lane_white, bblc_pkg::ORDER_GRBG, 1'b1, 14'd2));
        pixel_list = {16'h1234, 16'hFFFF, 16'h0001, 16'h2345};
        stream_pixels();
        apply_setting(make_setting(lane_black, lane_white, bblc_pkg::ORDER_GBRG, 1'b1, 14'd2));
        pixel_list = {16'h0301, 16'h8000, 16'h0100, 16'h7FFF};
        stream_pixels();
        apply_setting(make_setting(lane_black, lane_white, bblc_pkg::ORDER_BGGR, 1'b1, 14'd2));
        pixel_list = {16'h0405, 16'h0300, 16'hFFFF, 16'h0000};
        stream_pixels();

        // A line width of zero ends a line on every pixel; black levels at the
        // top and white limits at zero force every result to zero.
        apply_setting(make_setting('1, '0, bblc_pkg::ORDER_BGGR, 1'b1, 14'd0));
        pixel_list = {16'hFFFF, 16'h8000};
        stream_pixels();

        // An oversized width saturates to the largest line.
        apply_setting(make_setting('0, '1, bblc_pkg::ORDER_GRBG, 1'b1, 14'h3FFF));
        pixel_list = {16'hFFFF, 16'h0001};
        stream_pixels();

        // Random part: each phase takes a fresh setting and a run of pixels,
        // and the block is drained between phases.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            apply_setting(random_setting());
            count = $urandom_range(30, 130);
            pixel_list.delete();
            for (int i = 0; i < count; i++)
                pixel_list.push_back(random_pixel());
            stream_pixels();
            random_sent += count;
        end

        // Any stray result in this window is reported as unexpected.
        repeat (TRAILING_WAIT) @(posedge clk);
        if (pixel_check.pending_pixels.size() != 0)
            pixel_check.report($sformatf("%0d results never arrived",
                                         pixel_check.pending_pixels.size()));

        if (pixel_check.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== bayer_black_level_correct_top.f =====
rtl/bblc_pkg.sv
rtl/bblc_pos.sv
rtl/bblc_correct.sv
rtl/bayer_black_level_correct_top.sv
test/bayer_black_level_correct_top_test.sv
